// ===== hw/rtl/iobs_pkg.sv =====
// ----------------------------------------------------------------------------
// IMU offset bracket search package
// Shared constants, types and state codes for the offset calibrator.
// ----------------------------------------------------------------------------
`default_nettype none
package iobs_pkg;

    localparam int AXES         = 6;
    localparam int OFF_BITS     = 16;
    localparam int SAMPLE_BITS  = 16;
    localparam int SUM_BITS     = 32;
    localparam int CNT_BITS     = 16;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 16;
    localparam int Z_AXIS       = 2;

    localparam logic [15:0] FAST_RESET   = 16'd1000;
    localparam logic [15:0] SLOW_RESET   = 16'd10000;
    localparam logic [13:0] STEP_RESET   = 14'd1000;
    localparam logic [9:0]  NARROW_RESET = 10'd10;
    localparam logic [15:0] ZTGT_RESET   = 16'd16384;

    localparam logic [CFG_IDX_BITS-1:0] REG_FAST   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SLOW   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_STEP   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_NARROW = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_ZTGT   = 3'd4;

    localparam logic [1:0] PH_LOW   = 2'd0;
    localparam logic [1:0] PH_HIGH  = 2'd1;
    localparam logic [1:0] PH_CLOSE = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_UPDATE,
        ST_CLOSE,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        logic accum;
        logic div_start;
        logic update;
        logic close;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic round_end;
        logic div_done;
        logic phase_done;
        logic emit_now;
    } sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/iobs_if.sv =====
// ----------------------------------------------------------------------------
// IMU offset bracket search channels
// Valid/ready channels for samples, results and configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none
interface iobs_in_if #(parameter int SAMPLE_BITS = iobs_pkg::SAMPLE_BITS);
    logic valid;
    logic ready;
    logic kind;
    logic signed [SAMPLE_BITS-1:0] accel_x;
    logic signed [SAMPLE_BITS-1:0] accel_y;
    logic signed [SAMPLE_BITS-1:0] accel_z;
    logic signed [SAMPLE_BITS-1:0] gyro_x;
    logic signed [SAMPLE_BITS-1:0] gyro_y;
    logic signed [SAMPLE_BITS-1:0] gyro_z;
    modport source (output valid, kind, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                    input ready);
    modport sink (input valid, kind, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                  output ready);
endinterface

interface iobs_out_if;
    logic valid;
    logic ready;
    logic signed [15:0] apply_accel_x;
    logic signed [15:0] apply_accel_y;
    logic signed [15:0] apply_accel_z;
    logic signed [15:0] apply_gyro_x;
    logic signed [15:0] apply_gyro_y;
    logic signed [15:0] apply_gyro_z;
    logic [1:0] phase;
    logic finished;
    modport source (output valid, apply_accel_x, apply_accel_y, apply_accel_z,
                    apply_gyro_x, apply_gyro_y, apply_gyro_z, phase, finished,
                    input ready);
    modport sink (input valid, apply_accel_x, apply_accel_y, apply_accel_z,
                  apply_gyro_x, apply_gyro_y, apply_gyro_z, phase, finished,
                  output ready);
endinterface

interface iobs_cfg_if;
    logic valid;
    logic ready;
    logic [2:0] index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/iobs_div.sv =====
// ----------------------------------------------------------------------------
// IMU offset bracket search divider
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
`default_nettype none
module iobs_div #(
    parameter int SUM_BITS = iobs_pkg::SUM_BITS
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic signed [SUM_BITS:0]   dividend,
    input  wire logic [15:0]                divisor,
    output logic                            done,
    output logic signed [SUM_BITS:0]        quotient
);
    localparam int W  = SUM_BITS + 1;
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  mag_reg, mag_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [16:0]   rem_reg, rem_next;
    logic [15:0]   dvs_reg, dvs_next;
    logic          neg_reg, neg_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [16:0]   trial;
    logic [16:0]   diff;

    always_comb
    begin
        mag_next  = mag_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {rem_reg[15:0], mag_reg[W-1]};
        diff  = trial - {1'b0, dvs_reg};
        if (start)
        begin
            neg_next  = dividend[W-1];
            mag_next  = dividend[W-1] ? W'(-dividend) : W'(dividend);
            dvs_next  = divisor;
            rem_next  = '0;
            quo_next  = '0;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            mag_next = {mag_reg[W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = diff;
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);
endmodule
`default_nettype wire

// ===== hw/rtl/iobs_datapath.sv =====
// ----------------------------------------------------------------------------
// IMU offset bracket search datapath
// Axis sums, brackets, trial offsets, per-axis averaging and result register.
// ----------------------------------------------------------------------------
`default_nettype none
module iobs_datapath #(
    parameter int SAMPLE_BITS = iobs_pkg::SAMPLE_BITS,
    parameter int SUM_BITS    = iobs_pkg::SUM_BITS
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire iobs_pkg::cmd_t    cmd,
    output iobs_pkg::sts_t         sts,
    input  wire logic signed [SAMPLE_BITS-1:0] samp [iobs_pkg::AXES],
    input  wire logic [15:0]       fast_samples,
    input  wire logic [15:0]       slow_samples,
    input  wire logic [13:0]       expand_step,
    input  wire logic [9:0]        narrow_width,
    input  wire logic signed [15:0] z_accel_target,
    output logic signed [15:0]     res_off [iobs_pkg::AXES],
    output logic [1:0]             res_phase,
    output logic                   res_fin
);
    localparam int AXES = iobs_pkg::AXES;
    localparam int AW   = $clog2(AXES);

    logic signed [SUM_BITS-1:0] sum_reg [AXES];
    logic [15:0]        cnt_reg;
    logic signed [15:0] lo_reg [AXES];
    logic signed [15:0] hi_reg [AXES];
    logic signed [15:0] tr_reg [AXES];
    logic signed [SUM_BITS:0] avg_reg [AXES];
    logic [1:0]         phase_reg;
    logic               slow_reg;
    logic               narrow_reg;
    logic               done_reg;
    logic [AW-1:0]      ax_reg;
    logic               div_kick_reg;

    logic [15:0] n_eff;
    logic [15:0] cnt_inc;
    logic        div_done;
    logic signed [SUM_BITS:0] quo;
    logic signed [SUM_BITS:0] dividend;

    assign n_eff   = ((slow_reg ? slow_samples : fast_samples) == 16'd0) ? 16'd1
                   : (slow_reg ? slow_samples : fast_samples);
    assign cnt_inc = cnt_reg + 16'd1;
    assign dividend = (SUM_BITS+1)'(sum_reg[ax_reg]) + (SUM_BITS+1)'({1'b0, n_eff[15:1]});

    // Each division starts in the cycle after its trigger, so the first one sees
    // the sums that include the sample closing the round.
    iobs_div #(.SUM_BITS(SUM_BITS)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_kick_reg),
        .dividend (dividend),
        .divisor  (n_eff),
        .done     (div_done),
        .quotient (quo)
    );

    // Combinational view of the end-of-round bracket updates.
    logic signed [17:0] tgt [AXES];
    logic signed [15:0] lo_upd [AXES];
    logic signed [15:0] hi_upd [AXES];
    logic               narrow_upd;
    logic               again;
    logic signed [17:0] stepped;
    logic signed [15:0] cl_tr [AXES];
    logic               working;
    logic               slow_cl;
    logic               narrow_cl;
    logic signed [17:0] lsum;

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        if (v < -18'sd32768) return -16'sd32768;
        else if (v > 18'sd32767) return 16'sd32767;
        else return v[15:0];
    endfunction

    always_comb
    begin
        narrow_upd = narrow_reg;
        again      = narrow_reg;
        stepped    = '0;
        for (int i = 0; i < AXES; i++)
        begin
            tgt[i]    = (i == iobs_pkg::Z_AXIS) ? 18'(z_accel_target) : 18'sd0;
            lo_upd[i] = lo_reg[i];
            hi_upd[i] = hi_reg[i];
        end
        if (phase_reg == iobs_pkg::PH_LOW)
            narrow_upd = 1'b0;
        for (int i = 0; i < AXES; i++)
        begin
            if (phase_reg == iobs_pkg::PH_LOW)
            begin
                if (avg_reg[i] >= (SUM_BITS+1)'(tgt[i]))
                begin
                    narrow_upd = 1'b1;
                    stepped    = 18'(lo_reg[i]) - 18'($signed({1'b0, expand_step}));
                    lo_upd[i]  = sat16(stepped);
                end
            end
            else if (phase_reg == iobs_pkg::PH_HIGH)
            begin
                if (avg_reg[i] <= (SUM_BITS+1)'(tgt[i]))
                begin
                    again     = 1'b1;
                    stepped   = 18'(hi_reg[i]) + 18'($signed({1'b0, expand_step}));
                    hi_upd[i] = sat16(stepped);
                end
            end
            else
            begin
                if (avg_reg[i] > (SUM_BITS+1)'(tgt[i]))
                    hi_upd[i] = tr_reg[i];
                else
                    lo_upd[i] = tr_reg[i];
            end
        end
    end

    // Closing step on the registered brackets.
    always_comb
    begin
        working   = 1'b0;
        lsum      = '0;
        if (narrow_reg && !slow_reg)
        begin
            slow_cl   = 1'b1;
            narrow_cl = narrow_reg;
        end
        else
        begin
            slow_cl   = slow_reg;
            narrow_cl = 1'b1;
        end
        for (int i = 0; i < AXES; i++)
        begin
            if (18'(hi_reg[i]) <= 18'(lo_reg[i]) + 18'sd1)
                cl_tr[i] = lo_reg[i];
            else
            begin
                working  = 1'b1;
                lsum     = 18'(lo_reg[i]) + 18'(hi_reg[i]);
                // Truncating halving of a signed sum.
                cl_tr[i] = 16'((lsum + 18'(lsum[17])) >>> 1);
                if (18'(hi_reg[i]) > 18'(lo_reg[i]) + 18'($signed({1'b0, narrow_width})))
                    narrow_cl = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            phase_reg    <= iobs_pkg::PH_DONE;
            slow_reg     <= 1'b0;
            narrow_reg   <= 1'b0;
            done_reg     <= 1'b0;
            ax_reg       <= '0;
            div_kick_reg <= 1'b0;
            for (int i = 0; i < AXES; i++)
            begin
                sum_reg[i] <= '0;
                lo_reg[i]  <= '0;
                hi_reg[i]  <= '0;
                tr_reg[i]  <= '0;
                avg_reg[i] <= '0;
            end
        end
        else
        begin
            done_reg     <= 1'b0;
            div_kick_reg <= cmd.div_start || (div_done && (ax_reg != AW'(AXES - 1)));
            if (cmd.start)
            begin
                cnt_reg    <= '0;
                phase_reg  <= iobs_pkg::PH_LOW;
                slow_reg   <= 1'b0;
                narrow_reg <= 1'b0;
                for (int i = 0; i < AXES; i++)
                begin
                    sum_reg[i] <= '0;
                    lo_reg[i]  <= '0;
                    hi_reg[i]  <= '0;
                    tr_reg[i]  <= '0;
                end
            end
            else if (cmd.accum)
            begin
                cnt_reg <= cnt_inc;
                ax_reg  <= '0;
                for (int i = 0; i < AXES; i++)
                    sum_reg[i] <= sum_reg[i] + SUM_BITS'(samp[i]);
            end
            if (div_done)
            begin
                avg_reg[ax_reg] <= quo;
                if (ax_reg == AW'(AXES - 1))
                begin
                    done_reg <= 1'b1;
                    ax_reg   <= '0;
                end
                else
                    ax_reg <= ax_reg + 1'b1;
            end
            if (cmd.update)
            begin
                cnt_reg <= '0;
                for (int i = 0; i < AXES; i++)
                begin
                    sum_reg[i] <= '0;
                    lo_reg[i]  <= lo_upd[i];
                    hi_reg[i]  <= hi_upd[i];
                end
                if (phase_reg == iobs_pkg::PH_LOW)
                begin
                    narrow_reg <= narrow_upd;
                    phase_reg  <= iobs_pkg::PH_HIGH;
                    for (int i = 0; i < AXES; i++)
                        tr_reg[i] <= hi_reg[i];
                end
                else if (phase_reg == iobs_pkg::PH_HIGH)
                begin
                    if (again)
                    begin
                        phase_reg <= iobs_pkg::PH_LOW;
                        for (int i = 0; i < AXES; i++)
                            tr_reg[i] <= lo_upd[i];
                    end
                    else
                    begin
                        narrow_reg <= 1'b0;
                        phase_reg  <= iobs_pkg::PH_CLOSE;
                    end
                end
            end
            if (cmd.close)
            begin
                slow_reg   <= slow_cl;
                narrow_reg <= narrow_cl;
                phase_reg  <= working ? iobs_pkg::PH_CLOSE : iobs_pkg::PH_DONE;
                for (int i = 0; i < AXES; i++)
                    tr_reg[i] <= cl_tr[i];
            end
        end
    end

    // Result register: loaded once per emitted result.
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            res_phase <= phase_reg;
            res_fin   <= (phase_reg == iobs_pkg::PH_DONE);
            for (int i = 0; i < AXES; i++)
                res_off[i] <= (phase_reg == iobs_pkg::PH_DONE) ? lo_reg[i] : tr_reg[i];
        end
    end

    assign sts.round_end  = (cnt_inc >= n_eff);
    assign sts.div_done   = done_reg;
    assign sts.phase_done = (phase_reg == iobs_pkg::PH_DONE);
    assign sts.emit_now   = (phase_reg != iobs_pkg::PH_CLOSE);
endmodule
`default_nettype wire

// ===== hw/rtl/iobs_ctrl.sv =====
// ----------------------------------------------------------------------------
// IMU offset bracket search controller
// Sequences accumulation, averaging, bracket update and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none
module iobs_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic            in_kind,
    output logic                 in_ready,
    input  wire logic            out_busy,
    output logic                 out_set,
    output iobs_pkg::cmd_t       cmd,
    input  wire iobs_pkg::sts_t  sts
);
    iobs_pkg::state_t state_reg, state_next;
    logic take;

    assign take = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            iobs_pkg::ST_IDLE:
            begin
                if (take)
                begin
                    if (!in_kind)
                        state_next = iobs_pkg::ST_EMIT;
                    else if (!sts.phase_done && sts.round_end)
                        state_next = iobs_pkg::ST_DIV;
                end
            end
            iobs_pkg::ST_DIV:
                if (sts.div_done)
                    state_next = iobs_pkg::ST_UPDATE;
            iobs_pkg::ST_UPDATE:
                state_next = iobs_pkg::ST_CLOSE;
            iobs_pkg::ST_CLOSE:
                state_next = iobs_pkg::ST_EMIT;
            iobs_pkg::ST_EMIT:
                if (!out_busy)
                    state_next = iobs_pkg::ST_IDLE;
            default:
                state_next = iobs_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        out_set  = 1'b0;
        in_ready = 1'b0;
        case (state_reg)
            iobs_pkg::ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.start     = take && !in_kind;
                cmd.accum     = take && in_kind && !sts.phase_done;
                cmd.div_start = take && in_kind && !sts.phase_done && sts.round_end;
            end
            iobs_pkg::ST_DIV:
                if (sts.div_done)
                    cmd.update = 1'b1;
            iobs_pkg::ST_UPDATE:
                cmd.close = !sts.emit_now;
            iobs_pkg::ST_CLOSE:
                ;
            iobs_pkg::ST_EMIT:
            begin
                cmd.load_out = !out_busy;
                out_set      = !out_busy;
            end
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= iobs_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end
endmodule
`default_nettype wire

// ===== hw/rtl/imu_offset_bracket_search_top.sv =====
// ----------------------------------------------------------------------------
// IMU offset bracket search top level
// Six-axis offset calibrator with bracket expansion and bisection.
// ----------------------------------------------------------------------------
// A sample is accepted while the controller is idle; the sample that closes
// a round starts six averaging divisions in turn on one shared bit-serial
// divider and then the bracket update, after which the next offsets are
// loaded into the output register. A start request loads the zero offsets.
// The result sits in an output register, and the block takes further samples
// while it waits there; a new result waits to be loaded until the previous
// one is taken.
`default_nettype none
module imu_offset_bracket_search_top #(
    parameter int SAMPLE_BITS = iobs_pkg::SAMPLE_BITS,
    parameter int SUM_BITS    = iobs_pkg::SUM_BITS
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    iobs_in_if.sink    in_ch,
    iobs_out_if.source out_ch,
    iobs_cfg_if.sink   cfg
);
    localparam int AXES = iobs_pkg::AXES;

    logic [15:0] fast_reg, slow_reg;
    logic [13:0] step_reg;
    logic [9:0]  narrow_reg;
    logic signed [15:0] ztgt_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_reg   <= iobs_pkg::FAST_RESET;
            slow_reg   <= iobs_pkg::SLOW_RESET;
            step_reg   <= iobs_pkg::STEP_RESET;
            narrow_reg <= iobs_pkg::NARROW_RESET;
            ztgt_reg   <= iobs_pkg::ZTGT_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                iobs_pkg::REG_FAST:   fast_reg   <= cfg.data;
                iobs_pkg::REG_SLOW:   slow_reg   <= cfg.data;
                iobs_pkg::REG_STEP:   step_reg   <= cfg.data[13:0];
                iobs_pkg::REG_NARROW: narrow_reg <= cfg.data[9:0];
                iobs_pkg::REG_ZTGT:   ztgt_reg   <= cfg.data;
                default: ;
            endcase
        end
    end

    iobs_pkg::cmd_t cmd;
    iobs_pkg::sts_t sts;
    logic out_valid_reg;
    logic out_set;
    logic signed [SAMPLE_BITS-1:0] samp [AXES];
    logic signed [15:0] res_off [AXES];

    assign samp[0] = in_ch.accel_x;
    assign samp[1] = in_ch.accel_y;
    assign samp[2] = in_ch.accel_z;
    assign samp[3] = in_ch.gyro_x;
    assign samp[4] = in_ch.gyro_y;
    assign samp[5] = in_ch.gyro_z;

    iobs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_kind  (in_ch.kind),
        .in_ready (in_ch.ready),
        .out_busy (out_valid_reg && !out_ch.ready),
        .out_set  (out_set),
        .cmd      (cmd),
        .sts      (sts)
    );

    iobs_datapath #(.SAMPLE_BITS(SAMPLE_BITS), .SUM_BITS(SUM_BITS)) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .samp           (samp),
        .fast_samples   (fast_reg),
        .slow_samples   (slow_reg),
        .expand_step    (step_reg),
        .narrow_width   (narrow_reg),
        .z_accel_target (ztgt_reg),
        .res_off        (res_off),
        .res_phase      (out_ch.phase),
        .res_fin        (out_ch.finished)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_set)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.apply_accel_x = res_off[0];
    assign out_ch.apply_accel_y = res_off[1];
    assign out_ch.apply_accel_z = res_off[2];
    assign out_ch.apply_gyro_x  = res_off[3];
    assign out_ch.apply_gyro_y  = res_off[4];
    assign out_ch.apply_gyro_z  = res_off[5];
endmodule
`default_nettype wire

// ===== hw/rtl/iobs_checker.sv =====
// ----------------------------------------------------------------------------
// IMU offset bracket search checker
// Port-level properties of the calibrator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module iobs_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic [1:0] phase,
    input wire logic finished,
    input wire logic cfg_ready
);
    a_fin_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (finished == (phase == iobs_pkg::PH_DONE)))
        else $error("finished flag disagrees with phase");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(phase))
        else $error("stalled result changed");

    a_cfg: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("config port not ready");
endmodule

bind imu_offset_bracket_search_top iobs_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .phase     (out_ch.phase),
    .finished  (out_ch.finished),
    .cfg_ready (cfg.ready)
);
`default_nettype wire
